>>> sv/tkbmh_pkg.sv
// Package for the two-key binary max-heap.
// Holds the entry, transaction and state types and the status and command codes.
// No dependencies.
package tkbmh_pkg;

  typedef struct packed {
    logic [15:0] item_id;
    logic [31:0] mod_time;
    logic [15:0] version_count;
  } entry_t;

  typedef struct packed {
    logic        command;
    logic [15:0] item_id;
    logic [31:0] mod_time;
    logic [15:0] version_count;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_item_id;
    logic [31:0] out_mod_time;
    logic [15:0] out_version_count;
    logic [1:0]  status;
    logic [6:0]  entry_count;
  } out_item_t;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_UP_RD   = 8'b0000_0010,
    ST_UP_CMP  = 8'b0000_0100,
    ST_POP_LD  = 8'b0000_1000,
    ST_DN_RD   = 8'b0001_0000,
    ST_DN_CMPL = 8'b0010_0000,
    ST_DN_CMPR = 8'b0100_0000
  } state_t;

endpackage

>>> sv/tkbmh_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module tkbmh_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re0,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  output logic [WIDTH-1:0]         rdata0,
  input  logic                     re1,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re0) begin
      rdata0 <= mem[raddr0];
    end
    if (re1) begin
      rdata1 <= mem[raddr1];
    end
  end

endmodule

>>> sv/tkbmh_cmp.sv
// Shared key compare unit: selects the ordering key by mode and tests a > b.
// Depends on tkbmh_pkg.
module tkbmh_cmp
  import tkbmh_pkg::*;
(
  input  logic   recent_key,
  input  entry_t a,
  input  entry_t b,
  output logic   gt
);

  always_comb begin
    if (recent_key) begin
      gt = a.mod_time > b.mod_time;
    end else begin
      gt = a.version_count > b.version_count;
    end
  end

endmodule

>>> sv/two_key_binary_max_heap.sv
// Top level of the two-key binary max-heap: sequencer, heap RAM and compare unit.
// Depends on tkbmh_pkg, tkbmh_ram and tkbmh_cmp.
//
// Issue a push or pop with start while busy is low. The block then stays busy while
// it sifts the entry through the heap RAM, one level at a time, with a single key
// compare unit and a registered RAM read. A push reads the parent of each level, then
// compares and writes; a pop first reads the root and the last entry, then at each
// level reads both children and compares the left and then the right one before it
// writes. A pop on an empty heap or a push to a full heap does not raise busy. Each
// transaction yields exactly one result, shown for one cycle with out_strobe in the
// first cycle that busy is low again; the receiver cannot stall it. The heap RAM
// needs no clearing after reset.
module two_key_binary_max_heap
  import tkbmh_pkg::*;
#(
  parameter int HEAP_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  localparam int IDX_W = $clog2(HEAP_DEPTH);
  localparam int SZ_W  = $clog2(HEAP_DEPTH + 1);
  localparam int CH_W  = IDX_W + 2;

  state_t           state_r, state_nxt;
  logic [SZ_W-1:0]  size_r, size_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  entry_t           cur_r, cur_nxt;
  entry_t           best_r, best_nxt;
  logic             best_left_r, best_left_nxt;
  entry_t           res_r, res_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             strobe_r, strobe_nxt;
  out_item_t        out_r, out_nxt;
  logic             mode_r;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic             ram_re0, ram_re1;
  logic [IDX_W-1:0] ram_raddr0, ram_raddr1;
  entry_t           ram_rdata0, ram_rdata1;

  entry_t           cmp_a, cmp_b;
  logic             cmp_gt;

  logic [CH_W-1:0]  left_w, right_w, size_w;
  logic [IDX_W-1:0] parent_w;
  logic             accept;

  tkbmh_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(HEAP_DEPTH)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .re0    (ram_re0),
    .raddr0 (ram_raddr0),
    .rdata0 (ram_rdata0),
    .re1    (ram_re1),
    .raddr1 (ram_raddr1),
    .rdata1 (ram_rdata1)
  );

  tkbmh_cmp u_cmp (
    .recent_key (mode_r),
    .a          (cmp_a),
    .b          (cmp_b),
    .gt         (cmp_gt)
  );

  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;
  assign out_strobe = strobe_r;
  assign out_item   = out_r;

  assign left_w   = {1'b0, pos_r, 1'b1};
  assign right_w  = left_w + CH_W'(1);
  assign size_w   = CH_W'(size_r);
  assign parent_w = (pos_r - IDX_W'(1)) >> 1;

  always_comb begin
    cmp_a = cur_r;
    cmp_b = ram_rdata0;
    case (state_r)
      ST_UP_CMP: begin
        cmp_a = cur_r;
        cmp_b = ram_rdata0;
      end
      ST_DN_CMPL: begin
        cmp_a = ram_rdata0;
        cmp_b = cur_r;
      end
      ST_DN_CMPR: begin
        cmp_a = ram_rdata1;
        cmp_b = best_r;
      end
      default: begin
        cmp_a = cur_r;
        cmp_b = ram_rdata0;
      end
    endcase
  end

  always_comb begin
    logic finish;
    finish        = 1'b0;
    state_nxt     = state_r;
    size_nxt      = size_r;
    pos_nxt       = pos_r;
    cur_nxt       = cur_r;
    best_nxt      = best_r;
    best_left_nxt = best_left_r;
    res_nxt       = res_r;
    status_nxt    = status_r;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = cur_r;
    ram_re0       = 1'b0;
    ram_re1       = 1'b0;
    ram_raddr0    = '0;
    ram_raddr1    = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_nxt    = '0;
          status_nxt = STAT_OK;
          if (in_item.command == CMD_PUSH) begin
            if (size_r == SZ_W'(HEAP_DEPTH)) begin
              status_nxt = STAT_FULL;
              finish     = 1'b1;
            end else begin
              cur_nxt.item_id       = in_item.item_id;
              cur_nxt.mod_time      = in_item.mod_time;
              cur_nxt.version_count = in_item.version_count;
              pos_nxt               = size_r[IDX_W-1:0];
              size_nxt              = size_r + SZ_W'(1);
              state_nxt             = ST_UP_RD;
            end
          end else begin
            if (size_r == '0) begin
              status_nxt = STAT_EMPTY;
              finish     = 1'b1;
            end else begin
              ram_re0    = 1'b1;
              ram_re1    = 1'b1;
              ram_raddr0 = '0;
              ram_raddr1 = IDX_W'(size_r - SZ_W'(1));
              size_nxt   = size_r - SZ_W'(1);
              state_nxt  = ST_POP_LD;
            end
          end
        end
      end
      ST_UP_RD: begin
        if (pos_r == '0) begin
          ram_we    = 1'b1;
          ram_waddr = pos_r;
          ram_wdata = cur_r;
          finish    = 1'b1;
        end else begin
          ram_re0    = 1'b1;
          ram_raddr0 = parent_w;
          state_nxt  = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        if (cmp_gt) begin
          ram_wdata = ram_rdata0;
          pos_nxt   = parent_w;
          state_nxt = ST_UP_RD;
        end else begin
          ram_wdata = cur_r;
          finish    = 1'b1;
        end
      end
      ST_POP_LD: begin
        res_nxt = ram_rdata0;
        cur_nxt = ram_rdata1;
        pos_nxt = '0;
        if (size_r == '0) begin
          finish = 1'b1;
        end else begin
          state_nxt = ST_DN_RD;
        end
      end
      ST_DN_RD: begin
        if (left_w >= size_w) begin
          ram_we    = 1'b1;
          ram_waddr = pos_r;
          ram_wdata = cur_r;
          finish    = 1'b1;
        end else begin
          ram_re0    = 1'b1;
          ram_re1    = 1'b1;
          ram_raddr0 = left_w[IDX_W-1:0];
          ram_raddr1 = right_w[IDX_W-1:0];
          state_nxt  = ST_DN_CMPL;
        end
      end
      ST_DN_CMPL: begin
        if (cmp_gt) begin
          best_nxt      = ram_rdata0;
          best_left_nxt = 1'b1;
        end else begin
          best_nxt      = cur_r;
          best_left_nxt = 1'b0;
        end
        state_nxt = ST_DN_CMPR;
      end
      ST_DN_CMPR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        if ((right_w < size_w) && cmp_gt) begin
          ram_wdata = ram_rdata1;
          pos_nxt   = right_w[IDX_W-1:0];
          state_nxt = ST_DN_RD;
        end else if (best_left_r) begin
          ram_wdata = best_r;
          pos_nxt   = left_w[IDX_W-1:0];
          state_nxt = ST_DN_RD;
        end else begin
          ram_wdata = cur_r;
          finish    = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (finish) begin
      state_nxt                 = ST_IDLE;
      out_nxt.out_item_id       = res_nxt.item_id;
      out_nxt.out_mod_time      = res_nxt.mod_time;
      out_nxt.out_version_count = res_nxt.version_count;
      out_nxt.status            = status_nxt;
      out_nxt.entry_count       = 7'(size_nxt);
    end
    strobe_nxt = finish;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      size_r   <= '0;
      strobe_r <= 1'b0;
      mode_r   <= 1'b1;
    end else begin
      state_r  <= state_nxt;
      size_r   <= size_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    cur_r       <= cur_nxt;
    best_r      <= best_nxt;
    best_left_r <= best_left_nxt;
    res_r       <= res_nxt;
    status_r    <= status_nxt;
    out_r       <= out_nxt;
  end

`ifndef NO_ASSERTIONS
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while busy");

  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    size_r <= SZ_W'(HEAP_DEPTH))
    else $error("heap size above depth");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy || out_strobe))
    else $error("accepted transaction made no progress");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_item.status == STAT_EMPTY)) |-> (size_r == '0))
    else $error("empty status with entries held");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP_LD) |-> (size_r == $past(size_r) - SZ_W'(1)))
    else $error("pop did not shrink heap");
`endif

endmodule
